FILE: hdl/cps_pkg.sv
// Shared types and widths for the closest-point-on-segment pipeline.
package cps_pkg;

   localparam int COORD_W = 24;
   localparam int DIFF_W  = 25;
   localparam int PROD_W  = 50;
   localparam int SUM_W   = 52;
   // Squared length stays below 3 * 2^48, so a doubled remainder fits in 51 bits.
   localparam int REM_W   = 51;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic [REM_W-1:0]          rem_type;

   typedef enum logic [1:0] {
      REGION_START  = 2'd0,
      REGION_END    = 2'd1,
      REGION_INSIDE = 2'd2
   } region_type;

   typedef struct packed {
      coord_type [2:0] s;
      diff_type [2:0]  d;
      region_type      region;
   } geom_type;

   typedef struct packed {
      rem_type  rem;
      rem_type  den;
      geom_type geom;
   } div_tok_type;

endpackage

FILE: hdl/cps_front.sv
// Front end: differences, dot products and region classification in three stages.
module cps_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   output logic                    up_ready,
   input  cps_pkg::coord_type [2:0] s_pt,
   input  cps_pkg::coord_type [2:0] e_pt,
   input  cps_pkg::coord_type [2:0] p_pt,
   output logic                    dn_valid,
   input  logic                    dn_ready,
   output cps_pkg::div_tok_type    dn_tok
);
   import cps_pkg::*;

   logic a_valid_ff, b_valid_ff, c_valid_ff;
   logic a_ready, b_ready, c_ready;

   coord_type [2:0] a_s_ff, a_s_in;
   diff_type [2:0]  a_d_ff, a_d_in;
   diff_type [2:0]  a_a_ff, a_a_in;

   coord_type [2:0] b_s_ff;
   diff_type [2:0]  b_d_ff;
   prod_type [2:0]  b_ad_ff, b_ad_in;
   prod_type [2:0]  b_dd_ff, b_dd_in;

   div_tok_type c_tok_ff, c_tok_in;
   sum_type     dot, len;

   assign c_ready  = !c_valid_ff || dn_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign up_ready = a_ready;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_s_in[i] = s_pt[i];
         a_d_in[i] = diff_type'(e_pt[i]) - diff_type'(s_pt[i]);
         a_a_in[i] = diff_type'(p_pt[i]) - diff_type'(s_pt[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b_ad_in[i] = prod_type'(a_a_ff[i]) * prod_type'(a_d_ff[i]);
         b_dd_in[i] = prod_type'(a_d_ff[i]) * prod_type'(a_d_ff[i]);
      end
   end

   always_comb begin
      dot = sum_type'(b_ad_ff[0]) + sum_type'(b_ad_ff[1]) + sum_type'(b_ad_ff[2]);
      len = sum_type'(b_dd_ff[0]) + sum_type'(b_dd_ff[1]) + sum_type'(b_dd_ff[2]);
      c_tok_in.rem    = dot[REM_W-1:0];
      c_tok_in.den    = len[REM_W-1:0];
      c_tok_in.geom.s = b_s_ff;
      c_tok_in.geom.d = b_d_ff;
      if (len == '0 || dot < 0) begin
         c_tok_in.geom.region = REGION_START;
      end else if (dot > len) begin
         c_tok_in.geom.region = REGION_END;
      end else begin
         c_tok_in.geom.region = REGION_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= up_valid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && up_valid) begin
         a_s_ff <= a_s_in;
         a_d_ff <= a_d_in;
         a_a_ff <= a_a_in;
      end
      if (b_ready && a_valid_ff) begin
         b_s_ff  <= a_s_ff;
         b_d_ff  <= a_d_ff;
         b_ad_ff <= b_ad_in;
         b_dd_ff <= b_dd_in;
      end
      if (c_ready && b_valid_ff) begin
         c_tok_ff <= c_tok_in;
      end
   end

   assign dn_valid = c_valid_ff;
   assign dn_tok   = c_tok_ff;

endmodule

FILE: hdl/cps_div_cell.sv
// One restoring-division cell: produces one quotient bit of the ratio per stage.
module cps_div_cell #(
   parameter int FRACTION_BITS = 16,
   parameter bit FIRST_STEP    = 1'b0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  cps_pkg::div_tok_type       up_tok,
   input  logic [FRACTION_BITS:0]     up_quo,
   output logic                       dn_valid,
   input  logic                       dn_ready,
   output cps_pkg::div_tok_type       dn_tok,
   output logic [FRACTION_BITS:0]     dn_quo
);
   import cps_pkg::*;

   localparam int QW = FRACTION_BITS + 1;

   logic            valid_ff;
   div_tok_type     tok_ff, tok_in;
   logic [QW-1:0]   quo_ff, quo_in;
   rem_type         shifted;
   logic            take;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      // The first cell tests the integer bit; the rest shift in one fraction bit each.
      shifted = FIRST_STEP ? up_tok.rem : {up_tok.rem[REM_W-2:0], 1'b0};
      take    = shifted >= up_tok.den;
      tok_in     = up_tok;
      tok_in.rem = take ? shifted - up_tok.den : shifted;
      quo_in     = {up_quo[QW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         tok_ff <= tok_in;
         quo_ff <= quo_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_tok   = tok_ff;
   assign dn_quo   = quo_ff;

endmodule

FILE: hdl/cps_scale.sv
// Back end: scales the segment direction by the ratio and selects the result point.
module cps_scale #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     up_valid,
   output logic                     up_ready,
   input  cps_pkg::geom_type        up_geom,
   input  logic [FRACTION_BITS:0]   up_quo,
   output logic                     dn_valid,
   input  logic                     dn_ready,
   output cps_pkg::coord_type [2:0] dn_near,
   output cps_pkg::region_type      dn_region
);
   import cps_pkg::*;

   localparam int QW = FRACTION_BITS + 1;
   localparam int PW = QW + COORD_W;

   logic            m_valid_ff, o_valid_ff;
   logic            m_ready, o_ready;
   geom_type        m_geom_ff;
   logic [PW-1:0]   m_prod_ff [3];
   logic [PW-1:0]   m_prod_in [3];
   logic [COORD_W-1:0] mag [3];

   coord_type [2:0] near_ff, near_in;
   region_type      region_ff;
   diff_type        scaled [3];
   diff_type        delta [3];
   diff_type        sum [3];

   assign o_ready  = !o_valid_ff || dn_ready;
   assign m_ready  = !m_valid_ff || o_ready;
   assign up_ready = m_ready;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // The magnitude of a difference never exceeds 2^24 - 1.
         mag[i] = up_geom.d[i] < 0 ? COORD_W'(-up_geom.d[i]) : COORD_W'(up_geom.d[i]);
         m_prod_in[i] = PW'(up_quo) * PW'(mag[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         scaled[i] = diff_type'(m_prod_ff[i][FRACTION_BITS +: DIFF_W]);
         case (m_geom_ff.region)
            REGION_START:  delta[i] = '0;
            REGION_END:    delta[i] = m_geom_ff.d[i];
            REGION_INSIDE: delta[i] = m_geom_ff.d[i] < 0 ? -scaled[i] : scaled[i];
            default:       delta[i] = '0;
         endcase
         sum[i]     = diff_type'(m_geom_ff.s[i]) + delta[i];
         near_in[i] = sum[i][COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (m_ready) m_valid_ff <= up_valid;
         if (o_ready) o_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (m_ready && up_valid) begin
         m_geom_ff <= up_geom;
         for (int i = 0; i < 3; i++) begin
            m_prod_ff[i] <= m_prod_in[i];
         end
      end
      if (o_ready && m_valid_ff) begin
         near_ff   <= near_in;
         region_ff <= m_geom_ff.region;
      end
   end

   assign dn_valid  = o_valid_ff;
   assign dn_near   = near_ff;
   assign dn_region = region_ff;

endmodule

FILE: hdl/closest_point_on_segment.sv
// Closest point on a 3-D segment in Q12.12: top level wiring the pipeline together.
// The pipeline has three front-end stages, one division cell per quotient bit
// (FRACTION_BITS + 1 cells) and two scaling stages.
// Throughput is one request per cycle; every stage holds its data under backpressure.
// Synchronous active-high reset empties all stage valid bits; data registers keep no reset.
module closest_point_on_segment #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [23:0]        req_start_x,
   input  logic signed [23:0]        req_start_y,
   input  logic signed [23:0]        req_start_z,
   input  logic signed [23:0]        req_end_x,
   input  logic signed [23:0]        req_end_y,
   input  logic signed [23:0]        req_end_z,
   input  logic signed [23:0]        req_query_x,
   input  logic signed [23:0]        req_query_y,
   input  logic signed [23:0]        req_query_z,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [23:0]        rsp_near_x,
   output logic signed [23:0]        rsp_near_y,
   output logic signed [23:0]        rsp_near_z,
   output logic [1:0]                rsp_region
);
   import cps_pkg::*;

   localparam int QW    = FRACTION_BITS + 1;
   localparam int CELLS = FRACTION_BITS + 1;

   coord_type [2:0] s_pt, e_pt, p_pt;
   coord_type [2:0] near;
   region_type      region;

   logic          link_valid [CELLS+1];
   logic          link_ready [CELLS+1];
   div_tok_type   link_tok   [CELLS+1];
   logic [QW-1:0] link_quo   [CELLS+1];

   assign s_pt = {req_start_z, req_start_y, req_start_x};
   assign e_pt = {req_end_z, req_end_y, req_end_x};
   assign p_pt = {req_query_z, req_query_y, req_query_x};

   cps_front u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (req_ready),
      .s_pt     (s_pt),
      .e_pt     (e_pt),
      .p_pt     (p_pt),
      .dn_valid (link_valid[0]),
      .dn_ready (link_ready[0]),
      .dn_tok   (link_tok[0])
   );

   assign link_quo[0] = '0;

   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      cps_div_cell #(
         .FRACTION_BITS (FRACTION_BITS),
         .FIRST_STEP    (k == 0)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (link_valid[k]),
         .up_ready (link_ready[k]),
         .up_tok   (link_tok[k]),
         .up_quo   (link_quo[k]),
         .dn_valid (link_valid[k+1]),
         .dn_ready (link_ready[k+1]),
         .dn_tok   (link_tok[k+1]),
         .dn_quo   (link_quo[k+1])
      );
   end

   cps_scale #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (link_valid[CELLS]),
      .up_ready  (link_ready[CELLS]),
      .up_geom   (link_tok[CELLS].geom),
      .up_quo    (link_quo[CELLS]),
      .dn_valid  (rsp_valid),
      .dn_ready  (rsp_ready),
      .dn_near   (near),
      .dn_region (region)
   );

   assign rsp_near_x = near[0];
   assign rsp_near_y = near[1];
   assign rsp_near_z = near[2];
   assign rsp_region = region;

endmodule
